// ===== rtl/dns_query_name_lookup_relay_top_defines.svh =====
// Shared assertion macros for the relay checker.
`ifndef DNS_QUERY_NAME_LOOKUP_RELAY_TOP_DEFINES_SVH
`define DNS_QUERY_NAME_LOOKUP_RELAY_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define DQNL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define DQNL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dqnl_pkg.sv =====
package dqnl_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int NAME_MAX_DEF    = 64;
    localparam int ID_DEPTH_DEF    = 256;
    localparam int HEADER_BYTES    = 12;

    // Name lengths never exceed 255, so they always fit in one byte.
    localparam int QLEN_W = 8;
    localparam int SUM_W  = 10;
    localparam int HDR_W  = 4;

    localparam logic [7:0] LABEL_MAX = 8'd63;
    localparam logic [7:0] DOT_CHAR  = 8'h2E;

    localparam logic RESULT_QUERY = 1'b0;
    localparam logic RESULT_REPLY = 1'b1;

    typedef enum logic [1:0] {
        MODE_LOAD_NAME = 2'd0,
        MODE_LOAD_ADDR = 2'd1,
        MODE_QUERY     = 2'd2,
        MODE_REPLY     = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_LENGTH = 4'b0010,
        PH_LABEL  = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [QLEN_W-1:0] qlen;
        logic [15:0]       query_id;
        logic              bad;
        logic              done;
    } parse_status_t;

endpackage

// ===== rtl/dqnl_ram.sv =====
module dqnl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/dqnl_parser.sv =====
module dqnl_parser
    import dqnl_pkg::*;
#(
    parameter int NAME_MAX = NAME_MAX_DEF,
    localparam int QAW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            byte_en,
    input  logic [7:0]      data_byte,
    input  logic            clear,
    output parse_status_t   status,
    output logic            qn_we,
    output logic [QAW-1:0]  qn_waddr,
    output logic [7:0]      qn_wdata
);

    phase_t             phase_reg, phase_next;
    logic [HDR_W-1:0]   offset_reg, offset_next;
    logic [5:0]         rem_reg, rem_next;
    logic [QLEN_W-1:0]  qlen_reg, qlen_next;
    logic [15:0]        id_reg, id_next;
    logic               bad_reg, bad_next;
    logic [SUM_W-1:0]   need_sum;

    always_comb
    begin
        phase_next  = phase_reg;
        offset_next = offset_reg;
        rem_next    = rem_reg;
        qlen_next   = qlen_reg;
        id_next     = id_reg;
        bad_next    = bad_reg;
        qn_we       = 1'b0;
        qn_waddr    = qlen_reg[QAW-1:0];
        qn_wdata    = data_byte;
        need_sum    = SUM_W'(qlen_reg) + SUM_W'(data_byte)
                    + ((qlen_reg != '0) ? SUM_W'(1) : SUM_W'(0));
        if (byte_en)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (offset_reg == HDR_W'(0))
                    begin
                        id_next[15:8] = data_byte;
                    end
                    else if (offset_reg == HDR_W'(1))
                    begin
                        id_next[7:0] = data_byte;
                    end
                    if (offset_reg == HDR_W'(HEADER_BYTES - 1))
                    begin
                        phase_next = PH_LENGTH;
                    end
                    offset_next = offset_reg + HDR_W'(1);
                end
                PH_LENGTH:
                begin
                    if (data_byte == 8'd0)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (data_byte > LABEL_MAX || need_sum > SUM_W'(NAME_MAX))
                    begin
                        bad_next   = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        if (qlen_reg != '0)
                        begin
                            qn_we     = 1'b1;
                            qn_wdata  = DOT_CHAR;
                            qlen_next = qlen_reg + QLEN_W'(1);
                        end
                        rem_next   = data_byte[5:0];
                        phase_next = PH_LABEL;
                    end
                end
                PH_LABEL:
                begin
                    if (qlen_reg < QLEN_W'(NAME_MAX))
                    begin
                        qn_we     = 1'b1;
                        qlen_next = qlen_reg + QLEN_W'(1);
                    end
                    rem_next = rem_reg - 6'd1;
                    if (rem_reg == 6'd1)
                    begin
                        phase_next = PH_LENGTH;
                    end
                end
                PH_DONE:
                begin
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
        end
        if (clear)
        begin
            phase_next  = PH_HEADER;
            offset_next = '0;
            rem_next    = '0;
            qlen_next   = '0;
            id_next     = '0;
            bad_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            offset_reg <= '0;
            rem_reg    <= '0;
            qlen_reg   <= '0;
            id_reg     <= '0;
            bad_reg    <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            rem_reg    <= rem_next;
            qlen_reg   <= qlen_next;
            id_reg     <= id_next;
            bad_reg    <= bad_next;
        end
    end

    assign status.qlen     = qlen_reg;
    assign status.query_id = id_reg;
    assign status.bad      = bad_reg;
    assign status.done     = (phase_reg == PH_DONE);

endmodule

// ===== rtl/dns_query_name_lookup_relay_top.sv =====
// Load words and query bytes other than the last are taken while busy stays low.
// A reply word passes through S_RPLW, and a malformed last query byte through S_EVAL,
// before done is raised. A well-formed query is checked in S_EVAL, then each entry is
// visited in S_LEN and S_LENW; one of equal length goes on to S_BYTE until a byte differs.
// A hit ends the walk, a miss ends in S_LEN. Reset (asynchronous, active low) clears
// control state and the relay ring fill count; done strobes are never stalled.
module dns_query_name_lookup_relay_top
    import dqnl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int NAME_MAX    = NAME_MAX_DEF,
    parameter int ID_DEPTH    = ID_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        entry_count_we,
    input  logic [8:0]  entry_count,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [7:0]  entry_select,
    input  logic [31:0] entry_address,
    input  logic [31:0] client_address,
    input  logic [15:0] client_port,
    input  logic [15:0] reply_id,
    output logic        done,
    output logic        result_kind,
    output logic        malformed,
    output logic        found,
    output logic        blocked,
    output logic [7:0]  match_index,
    output logic [31:0] answer_address,
    output logic        answer_count,
    output logic [7:0]  assigned_id,
    output logic [15:0] original_id,
    output logic [31:0] client_address_out,
    output logic [15:0] client_port_out
);

    localparam int TW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int NAW    = $clog2(TABLE_DEPTH * NAME_MAX);
    localparam int QAW    = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
    localparam int IW     = $clog2(ID_DEPTH);
    localparam int RING_W = 64;

    // One-hot sequencer for the table walk and reply lookup.
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EVAL = 6'b000010,
        S_LEN  = 6'b000100,
        S_LENW = 6'b001000,
        S_BYTE = 6'b010000,
        S_RPLW = 6'b100000
    } state_t;

    state_t             state_reg;
    logic [8:0]         entry_count_reg;
    logic [QLEN_W-1:0]  load_pos_reg;
    logic [CNT_W-1:0]   i_reg, lim_reg;
    logic [QAW-1:0]     j_reg;
    logic [IW-1:0]      next_id_reg;
    logic               wrapped_reg;
    logic               rid_oor_reg, rid_known_reg;
    logic [31:0]        caddr_reg;
    logic [15:0]        cport_reg;

    logic               done_reg, kind_reg, malformed_reg, found_reg, blocked_reg;
    logic [7:0]         index_reg, assigned_reg;
    logic [31:0]        answer_reg, cout_addr_reg;
    logic               count_reg;
    logic [15:0]        orig_reg, cout_port_reg;

    logic               accept, sel_ok, rid_ok;
    logic [QLEN_W-1:0]  load_pos_next;
    logic               finish_hit;

    parse_status_t      pst;
    logic               qn_we;
    logic [QAW-1:0]     qn_waddr;
    logic [7:0]         qn_wdata;
    logic               parse_clear;

    logic               nm_we, nm_re, len_we, adr_we, ent_re, qn_re, ring_we, ring_re;
    logic [NAW-1:0]     nm_waddr, nm_raddr;
    logic [QAW-1:0]     qn_raddr;
    logic [7:0]         nm_rdata, qn_rdata;
    logic [QLEN_W-1:0]  len_rdata;
    logic [31:0]        adr_rdata;
    logic [RING_W-1:0]  ring_rdata, ring_wdata;
    logic [IW-1:0]      ring_raddr;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign sel_ok = ({24'd0, entry_select} < 32'(TABLE_DEPTH));
    assign rid_ok = ({1'b0, reply_id} < 17'(ID_DEPTH));

    // Name loading: bytes past the name limit are dropped, the length saturates.
    always_comb
    begin
        load_pos_next = load_pos_reg;
        if (load_pos_reg < QLEN_W'(NAME_MAX))
        begin
            load_pos_next = load_pos_reg + QLEN_W'(1);
        end
    end

    assign nm_we    = accept && (mode == MODE_LOAD_NAME) && sel_ok
                    && (load_pos_reg < QLEN_W'(NAME_MAX));
    assign nm_waddr = NAW'(entry_select) * NAW'(NAME_MAX) + NAW'(load_pos_reg);
    assign len_we   = accept && (mode == MODE_LOAD_NAME) && sel_ok && last_byte;
    assign adr_we   = accept && (mode == MODE_LOAD_ADDR) && sel_ok;

    // Table walk reads: entry length and address are read in S_LEN; name bytes are
    // read one per cycle alongside the matching byte of the decoded query name.
    assign ent_re   = (state_reg == S_LEN) && (i_reg != lim_reg);
    assign nm_re    = (state_reg == S_LENW) || (state_reg == S_BYTE);
    assign qn_re    = nm_re;
    assign qn_raddr = (state_reg == S_BYTE) ? (j_reg + QAW'(1)) : '0;
    assign nm_raddr = NAW'(i_reg) * NAW'(NAME_MAX) + NAW'(qn_raddr);

    // A hit is declared once the lengths agree and every byte has compared equal.
    assign finish_hit = ((state_reg == S_LENW) && (len_rdata == pst.qlen)
                            && (pst.qlen == '0))
                     || ((state_reg == S_BYTE) && (nm_rdata == qn_rdata)
                            && (QLEN_W'(j_reg) + QLEN_W'(1) == pst.qlen));

    assign ring_re    = accept && (mode == MODE_REPLY) && rid_ok;
    assign ring_raddr = IW'(reply_id);
    assign ring_wdata = {pst.query_id, caddr_reg, cport_reg};

    always_comb
    begin
        ring_we     = 1'b0;
        parse_clear = 1'b0;
        case (state_reg)
            S_EVAL:
            begin
                parse_clear = pst.bad || !pst.done;
            end
            S_LEN:
            begin
                ring_we     = (i_reg == lim_reg);
                parse_clear = (i_reg == lim_reg);
            end
            S_LENW, S_BYTE:
            begin
                ring_we     = finish_hit;
                parse_clear = finish_hit;
            end
            default:
            begin
            end
        endcase
    end

    dqnl_parser #(.NAME_MAX(NAME_MAX)) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_en   (accept && (mode == MODE_QUERY)),
        .data_byte (data_byte),
        .clear     (parse_clear),
        .status    (pst),
        .qn_we     (qn_we),
        .qn_waddr  (qn_waddr),
        .qn_wdata  (qn_wdata)
    );

    dqnl_ram #(.WIDTH(8), .DEPTH(NAME_MAX)) u_qname_ram (
        .clk(clk), .we(qn_we), .waddr(qn_waddr), .wdata(qn_wdata),
        .re(qn_re), .raddr(qn_raddr), .rdata(qn_rdata)
    );

    dqnl_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH * NAME_MAX)) u_name_ram (
        .clk(clk), .we(nm_we), .waddr(nm_waddr), .wdata(data_byte),
        .re(nm_re), .raddr(nm_raddr), .rdata(nm_rdata)
    );

    dqnl_ram #(.WIDTH(QLEN_W), .DEPTH(TABLE_DEPTH)) u_len_ram (
        .clk(clk), .we(len_we), .waddr(TW'(entry_select)), .wdata(load_pos_next),
        .re(ent_re), .raddr(i_reg[TW-1:0]), .rdata(len_rdata)
    );

    dqnl_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_addr_ram (
        .clk(clk), .we(adr_we), .waddr(TW'(entry_select)), .wdata(entry_address),
        .re(ent_re), .raddr(i_reg[TW-1:0]), .rdata(adr_rdata)
    );

    // Relay ring: written in order, so the fill count tells which entries exist.
    dqnl_ram #(.WIDTH(RING_W), .DEPTH(ID_DEPTH)) u_ring_ram (
        .clk(clk), .we(ring_we), .waddr(next_id_reg), .wdata(ring_wdata),
        .re(ring_re), .raddr(ring_raddr), .rdata(ring_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            entry_count_reg <= '0;
            load_pos_reg    <= '0;
            next_id_reg     <= '0;
            wrapped_reg     <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (entry_count_we)
            begin
                entry_count_reg <= entry_count;
            end
            if (ring_we)
            begin
                if (next_id_reg == IW'(ID_DEPTH - 1))
                begin
                    next_id_reg <= '0;
                    wrapped_reg <= 1'b1;
                end
                else
                begin
                    next_id_reg <= next_id_reg + IW'(1);
                end
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (mode)
                            MODE_LOAD_NAME:
                            begin
                                if (sel_ok)
                                begin
                                    load_pos_reg <= last_byte ? '0 : load_pos_next;
                                end
                            end
                            MODE_QUERY:
                            begin
                                if (last_byte)
                                begin
                                    state_reg <= S_EVAL;
                                end
                            end
                            MODE_REPLY:
                            begin
                                state_reg <= S_RPLW;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_EVAL:
                begin
                    if (pst.bad || !pst.done)
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_LEN;
                    end
                end
                S_LEN:
                begin
                    if (i_reg == lim_reg)
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_LENW;
                    end
                end
                S_LENW:
                begin
                    if (finish_hit)
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else if (len_rdata != pst.qlen)
                    begin
                        state_reg <= S_LEN;
                    end
                    else
                    begin
                        state_reg <= S_BYTE;
                    end
                end
                S_BYTE:
                begin
                    if (finish_hit)
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else if (nm_rdata != qn_rdata)
                    begin
                        state_reg <= S_LEN;
                    end
                end
                S_RPLW:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Walk counters, captured inputs and the result word.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                caddr_reg     <= client_address;
                cport_reg     <= client_port;
                rid_oor_reg   <= !rid_ok;
                rid_known_reg <= rid_ok && (wrapped_reg || (IW'(reply_id) < next_id_reg));
            end
            S_EVAL:
            begin
                i_reg <= '0;
                if ({23'd0, entry_count_reg} < 32'(TABLE_DEPTH))
                begin
                    lim_reg <= CNT_W'(entry_count_reg);
                end
                else
                begin
                    lim_reg <= CNT_W'(TABLE_DEPTH);
                end
                kind_reg      <= RESULT_QUERY;
                malformed_reg <= 1'b1;
                found_reg     <= 1'b0;
                blocked_reg   <= 1'b0;
                index_reg     <= '0;
                answer_reg    <= '0;
                count_reg     <= 1'b0;
                assigned_reg  <= '0;
                orig_reg      <= pst.query_id;
                cout_addr_reg <= caddr_reg;
                cout_port_reg <= cport_reg;
            end
            S_LEN:
            begin
                malformed_reg <= 1'b0;
                assigned_reg  <= 8'(next_id_reg);
            end
            S_LENW:
            begin
                j_reg <= '0;
                if (!finish_hit && (len_rdata != pst.qlen))
                begin
                    i_reg <= i_reg + CNT_W'(1);
                end
            end
            S_BYTE:
            begin
                if (!finish_hit)
                begin
                    if (nm_rdata != qn_rdata)
                    begin
                        i_reg <= i_reg + CNT_W'(1);
                    end
                    else
                    begin
                        j_reg <= j_reg + QAW'(1);
                    end
                end
            end
            S_RPLW:
            begin
                kind_reg      <= RESULT_REPLY;
                malformed_reg <= rid_oor_reg;
                found_reg     <= 1'b0;
                blocked_reg   <= 1'b0;
                index_reg     <= '0;
                answer_reg    <= '0;
                count_reg     <= 1'b0;
                assigned_reg  <= '0;
                orig_reg      <= rid_known_reg ? ring_rdata[63:48] : 16'd0;
                cout_addr_reg <= rid_known_reg ? ring_rdata[47:16] : 32'd0;
                cout_port_reg <= rid_known_reg ? ring_rdata[15:0]  : 16'd0;
            end
            default:
            begin
            end
        endcase
        if (finish_hit)
        begin
            found_reg    <= 1'b1;
            blocked_reg  <= (adr_rdata == 32'd0);
            index_reg    <= 8'(i_reg);
            answer_reg   <= adr_rdata;
            count_reg    <= (adr_rdata != 32'd0);
        end
    end

    assign done               = done_reg;
    assign result_kind        = kind_reg;
    assign malformed          = malformed_reg;
    assign found              = found_reg;
    assign blocked            = blocked_reg;
    assign match_index        = index_reg;
    assign answer_address     = answer_reg;
    assign answer_count       = count_reg;
    assign assigned_id        = assigned_reg;
    assign original_id        = orig_reg;
    assign client_address_out = cout_addr_reg;
    assign client_port_out    = cout_port_reg;

endmodule

// ===== rtl/dqnl_checker.sv =====
`include "dns_query_name_lookup_relay_top_defines.svh"

module dqnl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        busy,
    input logic        done,
    input logic        result_kind,
    input logic        malformed,
    input logic        found,
    input logic        blocked,
    input logic        answer_count
);

    `DQNL_ASSERT_NOW(a_done_after_busy, done, !busy && $past(busy), "result without a busy phase")
    `DQNL_ASSERT_NOW(a_count_rule, done && answer_count, found && !blocked, "bad answer count")
    `DQNL_ASSERT_NOW(a_malformed_nofind, done && malformed, !found, "malformed result with a match")
    `DQNL_ASSERT_NOW(a_reply_nofind, done && result_kind, !found && !answer_count, "reply has a match")
    `DQNL_ASSERT_NEXT(a_single_strobe, done, !done, "result strobe longer than one cycle")

endmodule

bind dns_query_name_lookup_relay_top dqnl_checker u_dqnl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .done         (done),
    .result_kind  (result_kind),
    .malformed    (malformed),
    .found        (found),
    .blocked      (blocked),
    .answer_count (answer_count)
);

// ===== tb/sv/dns_relay_checker.sv =====
`timescale 1ns / 1ps

module dns_relay_checker
    import dqnl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        entry_count_we,
    input  logic [8:0]  entry_count,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  mode,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [7:0]  entry_select,
    input  logic [31:0] entry_address,
    input  logic [31:0] client_address,
    input  logic [15:0] client_port,
    input  logic [15:0] reply_id,
    input  logic        done,
    input  logic        result_kind,
    input  logic        malformed,
    input  logic        found,
    input  logic        blocked,
    input  logic [7:0]  match_index,
    input  logic [31:0] answer_address,
    input  logic        answer_count,
    input  logic [7:0]  assigned_id,
    input  logic [15:0] original_id,
    input  logic [31:0] client_address_out,
    input  logic [15:0] client_port_out,
    output int          outstanding,
    output int          fail_count
);

    typedef struct packed {
        logic        kind;
        logic        bad;
        logic        hit;
        logic        blk;
        logic [7:0]  idx;
        logic [31:0] ans;
        logic        cnt;
        logic [7:0]  relay;
        logic [15:0] orig;
        logic [31:0] caddr;
        logic [15:0] cport;
    } relay_answer_t;

    localparam int DEPTH = 256;
    localparam int NMAX  = 64;

    logic [7:0]    dom_bytes [DEPTH][NMAX];
    logic [6:0]    dom_len [DEPTH];
    logic [31:0]   dom_addr [DEPTH];
    int unsigned   load_pos;
    logic [7:0]    qname [NMAX];
    int unsigned   qlen;
    int unsigned   qoffset;
    int unsigned   qremain;
    phase_t        qphase;
    logic [15:0]   qid;
    bit            qbad;
    logic [15:0]   ring_id [DEPTH];
    logic [31:0]   ring_addr [DEPTH];
    logic [15:0]   ring_port [DEPTH];
    logic [7:0]    ring_next;
    logic [8:0]    span;
    relay_answer_t answers_q[$];
    int            errs;

    task automatic clear_parse();
        qlen    = 0;
        qoffset = 0;
        qremain = 0;
        qphase  = PH_HEADER;
        qid     = '0;
        qbad    = 1'b0;
    endtask

    task automatic parse_byte(input logic [7:0] b);
        int unsigned need;
        case (qphase)
            PH_HEADER:
            begin
                if (qoffset == 0)
                    qid[15:8] = b;
                else if (qoffset == 1)
                    qid[7:0] = b;
                if (qoffset + 1 >= HEADER_BYTES)
                    qphase = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                if (b == 0)
                    qphase = PH_DONE;
                else if (b > LABEL_MAX)
                begin
                    qbad   = 1'b1;
                    qphase = PH_DONE;
                end
                else
                begin
                    need = b + ((qlen > 0) ? 1 : 0);
                    if (qlen + need > NMAX)
                    begin
                        qbad   = 1'b1;
                        qphase = PH_DONE;
                    end
                    else
                    begin
                        if (qlen > 0)
                        begin
                            qname[qlen] = DOT_CHAR;
                            qlen++;
                        end
                        qremain = b;
                        qphase  = PH_LABEL;
                    end
                end
            end
            PH_LABEL:
            begin
                if (qlen < NMAX)
                begin
                    qname[qlen] = b;
                    qlen++;
                end
                qremain = (qremain - 1) & 6'h3F;
                if (qremain == 0)
                    qphase = PH_LENGTH;
            end
            default:
            begin
            end
        endcase
        if (qoffset < 16'hFFFF)
            qoffset++;
    endtask

    // Works out the answer, if any, that the accepted word causes.
    task automatic decide_word();
        relay_answer_t r;
        int unsigned   lim;
        int unsigned   i;
        bit            same;
        r = '0;
        case (mode_t'(mode))
            MODE_LOAD_NAME:
            begin
                if (load_pos < NMAX)
                begin
                    dom_bytes[entry_select][load_pos] = data_byte;
                    load_pos++;
                end
                if (last_byte)
                begin
                    dom_len[entry_select] = load_pos[6:0];
                    load_pos = 0;
                end
            end
            MODE_LOAD_ADDR:
                dom_addr[entry_select] = entry_address;
            MODE_REPLY:
            begin
                r.kind = RESULT_REPLY;
                if (reply_id >= DEPTH)
                    r.bad = 1'b1;
                else
                begin
                    r.orig  = ring_id[reply_id[7:0]];
                    r.caddr = ring_addr[reply_id[7:0]];
                    r.cport = ring_port[reply_id[7:0]];
                end
                answers_q.push_back(r);
            end
            default:
            begin
                parse_byte(data_byte);
                if (last_byte)
                begin
                    r.kind  = RESULT_QUERY;
                    r.orig  = qid;
                    r.caddr = client_address;
                    r.cport = client_port;
                    if (qbad || qphase != PH_DONE)
                        r.bad = 1'b1;
                    else
                    begin
                        lim = (span < DEPTH) ? span : DEPTH;
                        for (i = 0; i < lim; i++)
                        begin
                            same = (dom_len[i] == qlen);
                            for (int j = 0; j < qlen && same; j++)
                                if (dom_bytes[i][j] !== qname[j])
                                    same = 1'b0;
                            if (same)
                                break;
                        end
                        if (i < lim)
                        begin
                            r.hit = 1'b1;
                            r.blk = (dom_addr[i] == 0);
                            r.idx = i[7:0];
                            r.ans = dom_addr[i];
                            r.cnt = !r.blk;
                        end
                        r.relay = ring_next;
                        ring_id[ring_next]   = qid;
                        ring_addr[ring_next] = client_address;
                        ring_port[ring_next] = client_port;
                        ring_next++;
                    end
                    answers_q.push_back(r);
                    clear_parse();
                end
            end
        endcase
    endtask

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", fname, want, got);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        relay_answer_t w;
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                ring_id[k]   = '0;
                ring_addr[k] = '0;
                ring_port[k] = '0;
            end
            ring_next = '0;
            load_pos  = 0;
            span      = '0;
            errs      = 0;
            answers_q.delete();
            clear_parse();
            outstanding <= 0;
            fail_count  <= 0;
        end
        else
        begin
            if (entry_count_we)
                span = entry_count;
            if (done)
            begin
                if (answers_q.size() == 0)
                begin
                    $error("result word with no expected answer waiting");
                    errs++;
                end
                else
                begin
                    w = answers_q.pop_front();
                    check_field("result_kind", w.kind, result_kind);
                    check_field("malformed", w.bad, malformed);
                    check_field("found", w.hit, found);
                    check_field("blocked", w.blk, blocked);
                    check_field("match_index", w.idx, match_index);
                    check_field("answer_address", w.ans, answer_address);
                    check_field("answer_count", w.cnt, answer_count);
                    check_field("assigned_id", w.relay, assigned_id);
                    check_field("original_id", w.orig, original_id);
                    check_field("client_address_out", w.caddr, client_address_out);
                    check_field("client_port_out", w.cport, client_port_out);
                end
            end
            if (start && !busy)
                decide_word();
            outstanding <= answers_q.size();
            fail_count  <= errs;
        end
    end

endmodule

// ===== tb/sv/tb_dns_query_name_lookup_relay_top.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the relay lookup block. The checker beside the
// block predicts and compares every result word; this module only drives.
module tb_dns_query_name_lookup_relay_top;
    import dqnl_pkg::*;

    // Table entries that get names and addresses before any search; every
    // search span stays within them unless a hit ends the walk earlier.
    localparam int FILLED = 32;

    logic        clk;
    logic        rst_n;
    logic        entry_count_we;
    logic [8:0]  entry_count;
    logic        start;
    logic        busy;
    logic [1:0]  mode;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [7:0]  entry_select;
    logic [31:0] entry_address;
    logic [31:0] client_address;
    logic [15:0] client_port;
    logic [15:0] reply_id;
    logic        done;
    logic        result_kind;
    logic        malformed;
    logic        found;
    logic        blocked;
    logic [7:0]  match_index;
    logic [31:0] answer_address;
    logic        answer_count;
    logic [7:0]  assigned_id;
    logic [15:0] original_id;
    logic [31:0] client_address_out;
    logic [15:0] client_port_out;
    int          outstanding;
    int          fail_count;

    // Our own copy of the dotted names in the table, used to build queries
    // and to reload entries. The checker keeps the authoritative state.
    logic [7:0]  dom_name [256][$];
    logic [7:0]  frame[$];
    logic [31:0] q_caddr;
    logic [15:0] q_cport;
    int          idle_pct;
    int          mix_pct;
    int          words_sent;

    dns_query_name_lookup_relay_top u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .entry_count_we     (entry_count_we),
        .entry_count        (entry_count),
        .start              (start),
        .busy               (busy),
        .mode               (mode),
        .data_byte          (data_byte),
        .last_byte          (last_byte),
        .entry_select       (entry_select),
        .entry_address      (entry_address),
        .client_address     (client_address),
        .client_port        (client_port),
        .reply_id           (reply_id),
        .done               (done),
        .result_kind        (result_kind),
        .malformed          (malformed),
        .found              (found),
        .blocked            (blocked),
        .match_index        (match_index),
        .answer_address     (answer_address),
        .answer_count       (answer_count),
        .assigned_id        (assigned_id),
        .original_id        (original_id),
        .client_address_out (client_address_out),
        .client_port_out    (client_port_out)
    );

    dns_relay_checker u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .entry_count_we     (entry_count_we),
        .entry_count        (entry_count),
        .start              (start),
        .busy               (busy),
        .mode               (mode),
        .data_byte          (data_byte),
        .last_byte          (last_byte),
        .entry_select       (entry_select),
        .entry_address      (entry_address),
        .client_address     (client_address),
        .client_port        (client_port),
        .reply_id           (reply_id),
        .done               (done),
        .result_kind        (result_kind),
        .malformed          (malformed),
        .found              (found),
        .blocked            (blocked),
        .match_index        (match_index),
        .answer_address     (answer_address),
        .answer_count       (answer_count),
        .assigned_id        (assigned_id),
        .original_id        (original_id),
        .client_address_out (client_address_out),
        .client_port_out    (client_port_out),
        .outstanding        (outstanding),
        .fail_count         (fail_count)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Hard stop in case the block hangs; far beyond the slowest legal run.
    initial
    begin
        #300_000_000;
        $display("FAIL");
        $finish;
    end

    // Offers one word and holds it until the block takes it. The start line
    // is left high afterwards so back-to-back words follow without a gap;
    // an optional gap first lowers it, each cycle idle with the set odds.
    task automatic put_word(input mode_t m, input logic [7:0] d, input bit lst,
                            input logic [7:0] sel, input logic [31:0] ea,
                            input logic [15:0] rid);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start          <= 1'b1;
        mode           <= m;
        data_byte      <= d;
        last_byte      <= lst;
        entry_select   <= sel;
        entry_address  <= ea;
        client_address <= q_caddr;
        client_port    <= q_cport;
        reply_id       <= rid;
        do
            @(posedge clk);
        while (busy);
        words_sent++;
    endtask

    // Lowers start after a run of words so nothing further is accepted.
    task automatic release_bus();
        start <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every expected result has come back and the walk is over.
    task automatic drain();
        release_bus();
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic set_span(input logic [8:0] v);
        drain();
        entry_count_we <= 1'b1;
        entry_count    <= v;
        @(posedge clk);
        entry_count_we <= 1'b0;
        entry_count    <= 9'($urandom);
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_addr();
        return ($urandom_range(99) < 15) ? 32'h0 : $urandom;
    endfunction

    function automatic logic [15:0] pick_relay();
        return ($urandom_range(99) < 80) ? 16'($urandom_range(0, 255))
                                         : 16'($urandom_range(0, 65535));
    endfunction

    task automatic load_entry(input logic [7:0] sel, input logic [7:0] nm[$],
                              input logic [31:0] a);
        dom_name[sel].delete();
        foreach (nm[k])
        begin
            put_word(MODE_LOAD_NAME, nm[k], k == nm.size() - 1, sel, $urandom,
                     16'($urandom));
            if (k < 64)
                dom_name[sel].push_back(nm[k]);
        end
        put_word(MODE_LOAD_ADDR, 8'($urandom), 1'b0, sel, a, 16'($urandom));
    endtask

    // Short names over a tiny alphabet, so duplicates and near misses occur.
    task automatic make_name(output logic [7:0] nm[$]);
        int labels;
        nm.delete();
        labels = $urandom_range(1, 3);
        for (int l = 0; l < labels; l++)
        begin
            if (l > 0)
                nm.push_back(DOT_CHAR);
            repeat ($urandom_range(1, 4))
                nm.push_back(8'h61 + 8'($urandom_range(0, 3)));
        end
    endtask

    task automatic begin_frame();
        frame.delete();
        repeat (HEADER_BYTES)
            frame.push_back(8'($urandom));
    endtask

    // Appends a dotted name in label form with its terminating zero.
    task automatic add_name(input logic [7:0] nm[$]);
        logic [7:0] lab[$];
        for (int k = 0; k <= nm.size(); k++)
        begin
            if (k == nm.size() || nm[k] == DOT_CHAR)
            begin
                frame.push_back(8'(lab.size()));
                foreach (lab[j])
                    frame.push_back(lab[j]);
                lab.delete();
            end
            else
                lab.push_back(nm[k]);
        end
        frame.push_back(8'h00);
    endtask

    task automatic add_label(input int len, input logic [7:0] ch);
        frame.push_back(8'(len));
        repeat (len)
            frame.push_back(ch);
    endtask

    task automatic add_trailer();
        repeat ($urandom_range(0, 4))
            frame.push_back(8'($urandom));
    endtask

    // Sends the frame as one datagram. Now and then a reply or an address
    // load is slipped in between bytes; neither may disturb the parse.
    task automatic send_frame();
        q_caddr = $urandom;
        q_cport = 16'($urandom);
        foreach (frame[k])
        begin
            if ($urandom_range(99) < mix_pct)
            begin
                if ($urandom_range(1))
                    put_word(MODE_REPLY, 8'($urandom), 1'($urandom), 8'($urandom),
                             $urandom, pick_relay());
                else
                    put_word(MODE_LOAD_ADDR, 8'($urandom), 1'($urandom),
                             8'($urandom), pick_addr(), 16'($urandom));
            end
            put_word(MODE_QUERY, frame[k], k == frame.size() - 1, 8'($urandom),
                     $urandom, 16'($urandom));
        end
    endtask

    task automatic random_word();
        int         c;
        logic [7:0] nm[$];
        c = $urandom_range(99);
        if (c < 70)
        begin
            begin_frame();
            c = $urandom_range(99);
            if (c < 60)
            begin
                add_name(dom_name[$urandom_range(0, FILLED - 1)]);
                add_trailer();
            end
            else if (c < 78)
            begin
                // Random labels with arbitrary bytes; mostly misses.
                repeat ($urandom_range(1, 3))
                begin
                    frame.push_back(8'($urandom_range(1, 6)));
                    repeat (frame[frame.size() - 1])
                        frame.push_back(8'($urandom));
                end
                frame.push_back(8'h00);
                add_trailer();
            end
            else if (c < 85)
            begin
                frame.push_back(8'($urandom_range(64, 255)));
                add_trailer();
                frame.push_back(8'($urandom));
            end
            else if (c < 91)
            begin
                repeat (3)
                    add_label($urandom_range(30, 63), 8'($urandom));
                frame.push_back(8'h00);
            end
            else
            begin
                // The datagram stops before the name is closed.
                add_name(dom_name[$urandom_range(0, FILLED - 1)]);
                frame = frame[0:$urandom_range(0, frame.size() - 2)];
            end
            send_frame();
        end
        else if (c < 85)
            put_word(MODE_REPLY, 8'($urandom), 1'($urandom), 8'($urandom), $urandom,
                     pick_relay());
        else if (c < 95)
            put_word(MODE_LOAD_ADDR, 8'($urandom), 1'($urandom), 8'($urandom),
                     pick_addr(), 16'($urandom));
        else
        begin
            make_name(nm);
            load_entry(8'($urandom_range(0, FILLED - 1)), nm, pick_addr());
        end
    endtask

    task automatic random_phase(input int pct, input logic [8:0] span, input int budget);
        int stop_at;
        set_span(span);
        idle_pct = pct;
        stop_at  = words_sent + budget;
        while (words_sent < stop_at)
            random_word();
    endtask

    initial
    begin
        logic [7:0] nm[$];

        rst_n          = 1'b0;
        entry_count_we = 1'b0;
        entry_count    = '0;
        start          = 1'b0;
        mode           = MODE_LOAD_NAME;
        data_byte      = '0;
        last_byte      = 1'b0;
        entry_select   = '0;
        entry_address  = '0;
        client_address = '0;
        client_port    = '0;
        reply_id       = '0;
        q_caddr        = '0;
        q_cport        = '0;
        idle_pct       = 0;
        mix_pct        = 0;
        words_sent     = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the searched part of the table.
        idle_pct = 10;
        for (int s = 0; s < FILLED; s++)
        begin
            make_name(nm);
            load_entry(8'(s), nm, pick_addr());
        end
        // Entry 3 repeats entry 1 so the first match must win, entry 2 is
        // blocked, and entry 200 gets a name longer than the store holds.
        load_entry(8'd3, dom_name[1], $urandom | 32'h1);
        load_entry(8'd1, dom_name[1], $urandom | 32'h1);
        load_entry(8'd2, dom_name[2], 32'h0);
        nm.delete();
        repeat (70)
            nm.push_back(8'h61);
        load_entry(8'd200, nm, 32'hFFFF_FFFF);

        // Two hits with the span above the table depth; each walk ends
        // within the filled entries.
        set_span(9'h1FF);
        begin_frame();
        frame[0] = 8'hFF;
        frame[1] = 8'hFF;
        add_name(dom_name[1]);
        repeat (4)
            frame.push_back(8'hFF);
        send_frame();
        begin_frame();
        frame[0] = 8'h00;
        frame[1] = 8'h00;
        add_name(dom_name[2]);
        send_frame();
        // Letters outside the table alphabet never match.
        set_span(9'(FILLED));
        begin_frame();
        add_label(2, 8'h7A);
        frame.push_back(8'h00);
        send_frame();
        // Compression pointer, then the smallest bad length byte.
        begin_frame();
        frame.push_back(8'hC0);
        frame.push_back(8'h0C);
        send_frame();
        begin_frame();
        add_label(64, 8'h61);
        frame.push_back(8'h00);
        send_frame();
        // Two long labels overflow the name; 31 + dot + 32 fills it exactly.
        begin_frame();
        add_label(63, 8'h62);
        add_label(63, 8'h63);
        frame.push_back(8'h00);
        send_frame();
        begin_frame();
        add_label(31, 8'h61);
        add_label(32, 8'h62);
        frame.push_back(8'h00);
        send_frame();
        // Datagrams that end inside the header, after one byte, and the root.
        begin_frame();
        frame = frame[0:4];
        send_frame();
        frame.delete();
        frame.push_back(8'h80);
        send_frame();
        begin_frame();
        frame.push_back(8'h00);
        send_frame();
        // Replies and address loads woven into every byte of a query.
        mix_pct = 100;
        begin_frame();
        add_name(dom_name[5]);
        send_frame();
        mix_pct = 0;
        put_word(MODE_REPLY, 8'h00, 1'b0, 8'h00, 32'h0, 16'd0);
        put_word(MODE_REPLY, 8'h00, 1'b0, 8'h00, 32'h0, 16'd255);
        put_word(MODE_REPLY, 8'h00, 1'b0, 8'h00, 32'h0, 16'd256);
        put_word(MODE_REPLY, 8'h00, 1'b0, 8'h00, 32'h0, 16'hFFFF);
        // An empty search span, then a span of one entry.
        set_span(9'd0);
        begin_frame();
        add_name(dom_name[0]);
        send_frame();
        set_span(9'd1);
        begin_frame();
        add_name(dom_name[0]);
        send_frame();

        // Random traffic: sender gaps at 22 %, then 68 %, then none.
        mix_pct = 6;
        random_phase(22, 9'd24, 100);
        random_phase(68, 9'd9, 100);
        random_phase(0, 9'(FILLED), 100);

        drain();
        repeat (30) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
